>>> design/pzp_pkg.sv
// ----------------------------------------------------------------------------
// pzp_pkg
// Shared types and constants for the parallactic zenith projection block.
// ----------------------------------------------------------------------------
package pzp_pkg;

  // Angle fields are fractions of a turn
  localparam int ANGLE_BITS = 32;
  // Angles are placed at the top of a 64-bit turn fraction
  localparam int TURN_BITS  = 64;
  localparam int OUT_BITS   = 32;
  // Quotient bits resolved by the divider chain (results stay below 2^33)
  localparam int QUOT_BITS  = 33;
  // Latency of one sine/cosine unit in register stages
  localparam int SC_LAT     = 15;

  localparam logic [31:0] HALF_PI_Q31 = 32'hC90F_DAA2;
  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;

  // Horner divisors, innermost term first
  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;
  localparam int SIN_DIVS [SIN_STEPS] = '{110, 72, 42, 20, 6};
  localparam int COS_DIVS [COS_STEPS] = '{132, 90, 56, 30, 12, 2};

  // Quadrant codes of a turn
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  typedef struct packed {
    logic        [ANGLE_BITS-1:0] ra_center;
    logic signed [ANGLE_BITS-1:0] dec_center;
    logic        [ANGLE_BITS-1:0] local_sidereal;
  } pzp_in_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] xi;
    logic signed [OUT_BITS-1:0] eta;
    logic                       below_horizon;
    logic                       saturated;
  } pzp_out_t;

endpackage

>>> design/pzp_horner_cell.sv
// ----------------------------------------------------------------------------
// pzp_horner_cell
// One Horner step t' = 1 - ((x2 * t) >> 31) / DIV in Q31, two register stages.
// ----------------------------------------------------------------------------
module pzp_horner_cell #(
  parameter int DIV = 2
) (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] x2_i,
  input  logic [31:0] t_i,
  output logic [30:0] x2_o,
  output logic [31:0] t_o
);
  import pzp_pkg::*;

  // Exact reciprocal for dividends below 2^31
  localparam int          SH  = 31 + $clog2(DIV);
  localparam logic [63:0] RCP_W = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [32:0] RCP = RCP_W[32:0];

  logic [62:0] prod;
  logic [30:0] p;
  logic [30:0] x2_a;
  logic [63:0] qprod;
  logic [30:0] quo;

  // stage A: scale by x^2
  assign prod = x2_i * t_i;

  always_ff @(posedge clk) begin
    if (en) begin
      p    <= prod[61:31];
      x2_a <= x2_i;
    end
  end

  // stage B: divide by the term constant
  assign qprod = p * RCP;
  assign quo   = 31'(qprod >> SH);

  always_ff @(posedge clk) begin
    if (en) begin
      t_o  <= ONE_Q31 - {1'b0, quo};
      x2_o <= x2_a;
    end
  end

endmodule

>>> design/pzp_sincos.sv
// ----------------------------------------------------------------------------
// pzp_sincos
// Sine and cosine of a turn fraction in Q30, in SC_LAT register stages.
// ----------------------------------------------------------------------------
module pzp_sincos (
  input  logic                           clk,
  input  logic                           en,
  input  logic [pzp_pkg::ANGLE_BITS-1:0] angle,
  output logic signed [31:0]             sin_o,
  output logic signed [31:0]             cos_o
);
  import pzp_pkg::*;

  logic [TURN_BITS-1:0] a64;
  logic [61:0]          f;
  logic                 swap;
  logic [61:0]          g;
  logic [63:0]          g_w;
  logic [30:0]          gs;
  logic [2:0]           meta;
  logic [2:0]           md [14];
  logic [62:0]          th_prod;
  logic [30:0]          th2;
  logic [61:0]          x2_prod;
  logic [30:0]          x2;
  logic [30:0]          td [11];
  logic [30:0]          sx2 [SIN_STEPS+1];
  logic [31:0]          st  [SIN_STEPS+1];
  logic [30:0]          cx2 [COS_STEPS+1];
  logic [31:0]          ct  [COS_STEPS+1];
  logic [62:0]          sp_prod;
  logic [30:0]          sp14;
  logic [30:0]          sp15;
  logic [31:0]          s0;
  logic [31:0]          c0;
  logic [32:0]          c_sum;
  logic signed [31:0]   s_next;
  logic signed [31:0]   c_next;

  // Fold into the first eighth of a turn
  assign a64  = {angle, {(TURN_BITS-ANGLE_BITS){1'b0}}};
  assign f    = a64[61:0];
  assign swap = f > (62'd1 << 61);
  assign g_w  = (64'd1 << 62) - {2'b00, f};
  assign g    = swap ? g_w[61:0] : f;
  assign gs   = g[61:31];
  assign meta = {swap, a64[63:62]};

  always_ff @(posedge clk) begin
    if (en) begin
      md[0] <= meta;
      for (int i = 1; i < 14; i++) md[i] <= md[i-1];
    end
  end

  // Radians, then x^2
  assign th_prod = gs * HALF_PI_Q31;
  assign x2_prod = th2 * th2;

  always_ff @(posedge clk) begin
    if (en) begin
      th2   <= th_prod[61:31];
      x2    <= x2_prod[61:31];
      td[0] <= th2;
      for (int i = 1; i < 11; i++) td[i] <= td[i-1];
    end
  end

  // Horner chains
  assign sx2[0] = x2;
  assign st[0]  = ONE_Q31;
  assign cx2[0] = x2;
  assign ct[0]  = ONE_Q31;

  for (genvar k = 0; k < SIN_STEPS; k++) begin : g_sin
    pzp_horner_cell #(.DIV(SIN_DIVS[k])) u_cell (
      .clk (clk), .en (en),
      .x2_i(sx2[k]), .t_i(st[k]), .x2_o(sx2[k+1]), .t_o(st[k+1])
    );
  end

  for (genvar k = 0; k < COS_STEPS; k++) begin : g_cos
    pzp_horner_cell #(.DIV(COS_DIVS[k])) u_cell (
      .clk (clk), .en (en),
      .x2_i(cx2[k]), .t_i(ct[k]), .x2_o(cx2[k+1]), .t_o(ct[k+1])
    );
  end

  // Sine series times the angle, then line up with the cosine chain
  assign sp_prod = td[10] * st[SIN_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sp14 <= sp_prod[61:31];
      sp15 <= sp14;
    end
  end

  // Round to Q30, undo the fold
  assign s0    = {1'b0, 31'((32'(sp15) + 32'd1) >> 1)};
  assign c_sum = {1'b0, ct[COS_STEPS]} + 33'd1;
  assign c0    = 32'(c_sum >> 1);

  always_comb begin
    logic [31:0] ss;
    logic [31:0] cc;
    ss = md[13][2] ? c0 : s0;
    cc = md[13][2] ? s0 : c0;
    case (md[13][1:0])
      QUAD_0: begin
        s_next = ss;
        c_next = cc;
      end
      QUAD_1: begin
        s_next = cc;
        c_next = -ss;
      end
      QUAD_2: begin
        s_next = -ss;
        c_next = -cc;
      end
      default: begin
        s_next = -cc;
        c_next = ss;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= s_next;
      cos_o <= c_next;
    end
  end

endmodule

>>> design/pzp_div_cell.sv
// ----------------------------------------------------------------------------
// pzp_div_cell
// One restoring division step: resolves quotient bit SHIFT, one stage.
// ----------------------------------------------------------------------------
module pzp_div_cell #(
  parameter int NUM_W = 87,
  parameter int DEN_W = 63,
  parameter int SHIFT = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [NUM_W-1:0]              rem_i,
  input  logic [DEN_W-1:0]              den_i,
  input  logic [pzp_pkg::QUOT_BITS-1:0] quo_i,
  output logic [NUM_W-1:0]              rem_o,
  output logic [DEN_W-1:0]              den_o,
  output logic [pzp_pkg::QUOT_BITS-1:0] quo_o
);
  import pzp_pkg::*;

  logic [NUM_W-1:0]     den_w;
  logic                 ge;
  logic [QUOT_BITS-1:0] quo_next;

  // Compare the remainder against the divisor at this bit weight
  assign den_w = {{(NUM_W-DEN_W){1'b0}}, den_i};
  assign ge    = (rem_i >> SHIFT) >= den_w;

  always_comb begin
    quo_next        = quo_i;
    quo_next[SHIFT] = ge;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? rem_i - (den_w << SHIFT) : rem_i;
      den_o <= den_i;
      quo_o <= quo_next;
    end
  end

endmodule

>>> design/parallactic_zenith_projection.sv
// ----------------------------------------------------------------------------
// parallactic_zenith_projection
// Zenith offset (xi, eta) from hour angle, declination and site latitude.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one pointing request
//   (ra_center, dec_center, local_sidereal). Output channel out_valid /
//   out_stall / out_data returns xi, eta (Q8.24), below_horizon, saturated.
//   site_latitude must be written through cfg_write / cfg_data while idle;
//   the block does not enforce this.
// Pipeline: 15 sine/cosine stages, 6 product and setup stages, 33 division
//   cells, 1 rounding stage and the output register; one request per cycle
//   while in_stall is low; every stage is a pipeline register.
// Reset: clears all valid bits and sets site_latitude to zero.
// Stall: a valid output register holds while out_stall is high; one result
//   more lands in a skid register. Once the skid is full in_stall rises and
//   the whole pipeline holds until the output register drains.
// ----------------------------------------------------------------------------
module parallactic_zenith_projection #(
  parameter int OUT_FRAC_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic signed [pzp_pkg::ANGLE_BITS-1:0] cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  pzp_pkg::pzp_in_t                      in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output pzp_pkg::pzp_out_t                     out_data
);
  import pzp_pkg::*;

  localparam int MW    = 63;
  localparam int NW    = MW + OUT_FRAC_BITS;
  localparam int NSTG  = SC_LAT + 6 + QUOT_BITS + 1;
  localparam logic [QUOT_BITS:0] POS_MAX = (34'd1 << 31) - 34'd1;
  localparam logic [QUOT_BITS:0] NEG_MAX = 34'd1 << 31;

  typedef struct packed {
    logic below;
    logic neg_x;
    logic neg_e;
    logic ovf_x;
    logic ovf_e;
  } side_t;

  logic signed [ANGLE_BITS-1:0] site_latitude;
  logic                         en;
  logic                         v [NSTG];
  logic                         skid_valid;
  pzp_out_t                     skid_data;
  pzp_out_t                     pipe_data;
  logic                         take;
  logic [ANGLE_BITS-1:0]        ha;
  logic signed [31:0]           sl, cl, sd, cd, sh, ch;

  // Latitude register
  always_ff @(posedge clk) begin
    if (rst) begin
      site_latitude <= '0;
    end else if (cfg_write) begin
      site_latitude <= cfg_data;
    end
  end

  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // Valid bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTG; i++) v[i] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) v[i] <= v[i-1];
    end
  end

  // Hour angle wraps modulo one turn
  assign ha = in_data.local_sidereal - in_data.ra_center;

  pzp_sincos u_sc_lat (
    .clk(clk), .en(en), .angle(site_latitude), .sin_o(sl), .cos_o(cl)
  );
  pzp_sincos u_sc_dec (
    .clk(clk), .en(en), .angle(in_data.dec_center), .sin_o(sd), .cos_o(cd)
  );
  pzp_sincos u_sc_ha (
    .clk(clk), .en(en), .angle(ha), .sin_o(sh), .cos_o(ch)
  );

  // Q60 to Q30, half away from zero
  function automatic logic signed [31:0] to_q30(input logic signed [63:0] val);
    logic [63:0] mag;
    logic [63:0] rnd;
    mag = val[63] ? 64'(-val) : 64'(val);
    rnd = (mag + (64'd1 << 29)) >> 30;
    return val[63] ? -(32'(rnd)) : 32'(rnd);
  endfunction

  // Product stages
  logic signed [63:0] p_clcd, p_clsd;
  logic signed [31:0] a_sl, a_sd, a_cd, a_cl, a_sh, a_ch;
  logic signed [31:0] b_sl, b_sd, b_cd, b_cl, b_sh, b_ch, clcd, clsd;
  logic signed [63:0] m1, m2, m3, m4, m5;
  logic signed [63:0] cosz, xnum, ynum;
  logic [MW-1:0]      mag_x, mag_e, den;
  logic               below5, neg_x5, neg_e5;
  logic [63:0]        abs_x, abs_e;

  always_ff @(posedge clk) begin
    if (en) begin
      p_clcd <= cl * cd;
      p_clsd <= cl * sd;
      a_sl <= sl; a_sd <= sd; a_cd <= cd; a_cl <= cl; a_sh <= sh; a_ch <= ch;
      clcd <= to_q30(p_clcd);
      clsd <= to_q30(p_clsd);
      b_sl <= a_sl; b_sd <= a_sd; b_cd <= a_cd; b_cl <= a_cl;
      b_sh <= a_sh; b_ch <= a_ch;
      m1 <= b_sl * b_sd;
      m2 <= clcd * b_ch;
      m3 <= b_cl * b_sh;
      m4 <= b_sl * b_cd;
      m5 <= clsd * b_ch;
      cosz <= m1 + m2;
      xnum <= m4 - m5;
      ynum <= m3;
    end
  end

  // Divider setup: signs and magnitudes
  assign abs_x = ynum[63] ? 64'(-ynum) : 64'(ynum);
  assign abs_e = xnum[63] ? 64'(-xnum) : 64'(xnum);

  always_ff @(posedge clk) begin
    if (en) begin
      below5 <= (cosz <= 64'sd0);
      neg_x5 <= ynum[63];
      neg_e5 <= xnum[63];
      mag_x  <= abs_x[MW-1:0];
      mag_e  <= abs_e[MW-1:0];
      den    <= cosz[MW-1:0];
    end
  end

  // Overflow precheck: quotient of 2^33 or more
  logic [NW-1:0] num_x, num_e, den_w;
  logic [NW-1:0] rem_x [QUOT_BITS+1];
  logic [NW-1:0] rem_e [QUOT_BITS+1];
  logic [MW-1:0] den_x [QUOT_BITS+1];
  logic [MW-1:0] den_e [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo_x [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] quo_e [QUOT_BITS+1];
  side_t side [QUOT_BITS+1];

  assign num_x = {mag_x, {OUT_FRAC_BITS{1'b0}}};
  assign num_e = {mag_e, {OUT_FRAC_BITS{1'b0}}};
  assign den_w = {{OUT_FRAC_BITS{1'b0}}, den};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_x[0] <= num_x;
      rem_e[0] <= num_e;
      den_x[0] <= den;
      den_e[0] <= den;
      side[0]  <= '{below: below5, neg_x: neg_x5, neg_e: neg_e5,
                    ovf_x: (num_x >> QUOT_BITS) >= den_w,
                    ovf_e: (num_e >> QUOT_BITS) >= den_w};
      for (int i = 1; i <= QUOT_BITS; i++) side[i] <= side[i-1];
    end
  end

  assign quo_x[0] = '0;
  assign quo_e[0] = '0;

  // Division cells, most significant quotient bit first
  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_div
    pzp_div_cell #(.NUM_W(NW), .DEN_W(MW), .SHIFT(QUOT_BITS-1-k)) u_x (
      .clk(clk), .en(en),
      .rem_i(rem_x[k]), .den_i(den_x[k]), .quo_i(quo_x[k]),
      .rem_o(rem_x[k+1]), .den_o(den_x[k+1]), .quo_o(quo_x[k+1])
    );
    pzp_div_cell #(.NUM_W(NW), .DEN_W(MW), .SHIFT(QUOT_BITS-1-k)) u_e (
      .clk(clk), .en(en),
      .rem_i(rem_e[k]), .den_i(den_e[k]), .quo_i(quo_e[k]),
      .rem_o(rem_e[k+1]), .den_o(den_e[k+1]), .quo_o(quo_e[k+1])
    );
  end

  // Round half up, apply sign, clip to the output range
  function automatic logic [OUT_BITS:0] finish(
    input logic [QUOT_BITS-1:0] quo,
    input logic [NW-1:0]        rem,
    input logic [MW-1:0]        dv,
    input logic                 ovf,
    input logic                 neg
  );
    logic           rnd;
    logic           over;
    logic [QUOT_BITS:0] qr;
    logic           sat;
    logic [OUT_BITS-1:0] val;
    rnd  = {rem[MW-1:0], 1'b0} >= {1'b0, dv};
    over = ovf || (quo > (33'd1 << 32));
    qr   = {1'b0, quo} + {{QUOT_BITS{1'b0}}, rnd};
    if (neg) begin
      sat = over || (qr > NEG_MAX);
      val = sat ? 32'h8000_0000 : 32'(-qr);
    end else begin
      sat = over || (qr > POS_MAX);
      val = sat ? 32'h7FFF_FFFF : qr[OUT_BITS-1:0];
    end
    return {sat, val};
  endfunction

  logic [OUT_BITS:0] fin_x, fin_e;
  side_t             sd_last;

  assign sd_last = side[QUOT_BITS];
  assign fin_x = finish(quo_x[QUOT_BITS], rem_x[QUOT_BITS], den_x[QUOT_BITS],
                        sd_last.ovf_x, sd_last.neg_x);
  assign fin_e = finish(quo_e[QUOT_BITS], rem_e[QUOT_BITS], den_e[QUOT_BITS],
                        sd_last.ovf_e, sd_last.neg_e);

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_data.below_horizon <= sd_last.below;
      pipe_data.xi            <= sd_last.below ? '0 : fin_x[OUT_BITS-1:0];
      pipe_data.eta           <= sd_last.below ? '0 : fin_e[OUT_BITS-1:0];
      pipe_data.saturated     <= !sd_last.below && (fin_x[OUT_BITS] || fin_e[OUT_BITS]);
    end
  end

  // Output register with one skid entry
  assign take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      out_valid  <= skid_valid || (en && v[NSTG-1]);
      skid_valid <= 1'b0;
    end else if (en && v[NSTG-1]) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= skid_valid ? skid_data : pipe_data;
    end else if (en && v[NSTG-1]) begin
      skid_data <= pipe_data;
    end
  end

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid holds a result ahead of output");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> (v[NSTG-1] == $past(v[NSTG-1])))
    else $error("pipeline moved while stalled");

  a_below_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.below_horizon) |->
      (out_data.xi == 0 && out_data.eta == 0 && !out_data.saturated))
    else $error("below horizon result not cleared");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.saturated) |->
      (out_data.xi == 32'sh7FFF_FFFF || out_data.xi == 32'sh8000_0000 ||
       out_data.eta == 32'sh7FFF_FFFF || out_data.eta == 32'sh8000_0000))
    else $error("saturated flag without clipped value");

endmodule
